/* hdl/spjq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spjq_pkg: shared types for the stable priority job queue
// Field widths, the stored slot layout and the result status codes.
// ----------------------------------------------------------------------------
package spjq_pkg;

   localparam int ID_W   = 16;
   localparam int PRIO_W = 8;
   localparam int OCC_W  = 5;

   // One stored job: priority beside its identifier.
   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   id;
   } slot_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

endpackage
`default_nettype wire

/* hdl/spjq_slot_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spjq_slot_ram: job slot memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module spjq_slot_ram #(
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire spjq_pkg::slot_type wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output spjq_pkg::slot_type      rd_data
);
   import spjq_pkg::*;

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/stable_priority_job_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_job_queue_top: bounded priority queue of jobs
// Sorted ring of job slots in one memory; stable insert, remove from head.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY jobs, sorted by priority with the highest at
// the head; a job goes behind every held job of equal or higher priority, so
// equal priorities leave first-in first-out. The slots form a ring in one
// memory (one write, one registered read per cycle), so a remove only moves
// the head pointer: S_RDHEAD takes the head job read from S_IDLE, then S_RESP
// hands it on. An insert into a non-empty queue walks back from the tail one
// slot per cycle through the single read port, moving each lower-priority job
// one place toward the tail, and writes the job in S_WALK or, past the head,
// in S_PLACE. A remove from an empty queue, an insert into a full one and an
// insert into an empty one go from S_IDLE straight to S_RESP. Every item gives
// exactly one result item; the result sits in an output register, and the
// next item is taken once the result has been handed to that register, so a
// result that still waits there adds its stall cycles.
// No clearing pass is needed after reset: only slots inside the ring are read.
// ----------------------------------------------------------------------------
module stable_priority_job_queue_top #(
   parameter int CAPACITY = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // item input channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_action,
   input  wire logic [spjq_pkg::ID_W-1:0]   req_job_id,
   input  wire logic [spjq_pkg::PRIO_W-1:0] req_job_priority,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [spjq_pkg::ID_W-1:0]        rsp_served_id,
   output logic [spjq_pkg::PRIO_W-1:0]      rsp_served_priority,
   output logic [spjq_pkg::OCC_W-1:0]       rsp_occupancy
);
   import spjq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_RDHEAD = 5'b00010,
      S_WALK   = 5'b00100,
      S_PLACE  = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   // Step a ring index forward or back.
   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
      return (x == AW'(CAPACITY - 1)) ? '0 : x + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
      return (x == '0) ? AW'(CAPACITY - 1) : x - 1'b1;
   endfunction

   // Control state
   state_type      state_ff, state_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  remain_ff, remain_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Payload registers
   slot_type       job_ff, job_in;
   status_type     pend_status_ff, pend_status_in;
   slot_type       pend_slot_ff, pend_slot_in;
   status_type     rsp_status_ff;
   slot_type       rsp_slot_ff;
   logic [CW-1:0]  rsp_count_ff;

   // Memory ports
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   slot_type       wr_data;
   logic [AW-1:0]  rd_addr;
   slot_type       rd_data;

   logic           accept;
   logic           out_free;
   logic           is_full;
   logic [AW:0]    tail_sum;
   logic [AW-1:0]  tail;
   logic [CW+4:0]  occ_ext;

   spjq_slot_ram #(
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Accept only in idle; every other state, the walk and the result hand-off among them, holds the input.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_full   = (count_ff == CW'(CAPACITY));

   // Physical slot just past the last held job.
   assign tail_sum = (AW+1)'(head_ff) + (AW+1)'(count_ff);
   assign tail     = (tail_sum >= (AW+1)'(CAPACITY)) ?
                     AW'(tail_sum - (AW+1)'(CAPACITY)) : tail_sum[AW-1:0];

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      remain_in      = remain_ff;
      pos_in         = pos_ff;
      job_in         = job_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = job_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               job_in.prio  = req_job_priority;
               job_in.id    = req_job_id;
               pend_slot_in = '0;
               if (req_action == ACT_REMOVE) begin
                  if (count_ff == '0) begin
                     pend_status_in = ST_EMPTY;
                     state_in       = S_RESP;
                  end else begin
                     // head read issued now, data next cycle
                     state_in = S_RDHEAD;
                  end
               end else if (is_full) begin
                  pend_status_in = ST_FULL;
                  state_in       = S_RESP;
               end else if (count_ff == '0) begin
                  // empty ring: drop the job straight at the head
                  wr_en          = 1'b1;
                  wr_addr        = head_ff;
                  wr_data        = job_in;
                  count_in       = CW'(1);
                  pend_status_in = ST_INSERTED;
                  state_in       = S_RESP;
               end else begin
                  // start the walk at the tail, reading the last held job
                  pos_in    = tail;
                  remain_in = count_ff;
                  state_in  = S_WALK;
               end
            end
         end

         S_RDHEAD: begin
            pend_slot_in   = rd_data;
            pend_status_in = ST_REMOVED;
            head_in        = ring_inc(head_ff);
            count_in       = count_ff - 1'b1;
            state_in       = S_RESP;
         end

         S_WALK: begin
            wr_en = 1'b1;
            if (rd_data.prio >= job_ff.prio) begin
               // stop behind an equal or higher priority job
               wr_data        = job_ff;
               count_in       = count_ff + 1'b1;
               pend_status_in = ST_INSERTED;
               state_in       = S_RESP;
            end else begin
               // move the lower-priority job one slot toward the tail
               wr_data   = rd_data;
               pos_in    = ring_dec(pos_ff);
               remain_in = remain_ff - 1'b1;
               if (remain_ff == CW'(1)) begin
                  state_in = S_PLACE;
               end
            end
         end

         S_PLACE: begin
            wr_en          = 1'b1;
            wr_data        = job_ff;
            count_in       = count_ff + 1'b1;
            pend_status_in = ST_INSERTED;
            state_in       = S_RESP;
         end

         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Head on a remove; otherwise one slot ahead of the walk position.
   assign rd_addr = (state_ff == S_IDLE && req_action == ACT_REMOVE) ?
                    head_ff : ring_dec(pos_in);

   // Output register: load in the hand-off state, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_RESP && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      if (state_ff == S_RESP && out_free) begin
         rsp_status_ff <= pend_status_ff;
         rsp_slot_ff   <= pend_slot_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   // Occupancy is the count masked to the 5-bit field.
   assign occ_ext = {5'b0, rsp_count_ff};

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_served_id       = rsp_slot_ff.id;
   assign rsp_served_priority = rsp_slot_ff.prio;
   assign rsp_occupancy       = occ_ext[4:0];

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("held count above capacity");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (remain_ff != '0 && count_ff != '0 && !is_full))
      else $error("tail walk outside the held ring");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PLACE) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("placed job not counted");

   a_no_served_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_REMOVED) |->
      (rsp_slot_ff.id == '0 && rsp_slot_ff.prio == '0))
      else $error("served fields set on a result without a removed job");
`endif

endmodule
`default_nettype wire
